// ===== rtl/rocm_pkg.sv =====
package rocm_pkg;

    localparam int GRID_SIDE_DEF = 1024;

    localparam int ID_W    = 12;
    localparam int POS_W   = 10;
    localparam int LEN_W   = 11;
    // Start plus length needs 12 bits, but an end never exceeds the grid side,
    // so every visited coordinate and every clipped end fits in 11 bits for a side up to 2047.
    localparam int COORD_W = 11;
    localparam int SUM_W   = 12;
    localparam int COUNT_W = 21;

    typedef enum logic [1:0] {
        CELL_EMPTY = 2'd0,
        CELL_ONCE  = 2'd1,
        CELL_MULTI = 2'd2
    } cell_t;

    typedef enum logic {
        CMD_PAINT = 1'b0,
        CMD_CHECK = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [ID_W-1:0]    id;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic               clipped;
        logic               empty;
    } item_t;

endpackage

// ===== rtl/rocm_front.sv =====
module rocm_front #(
    parameter int GRID_SIDE = rocm_pkg::GRID_SIDE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [rocm_pkg::ID_W-1:0]    claim_id,
    input  logic [rocm_pkg::POS_W-1:0]   x_start,
    input  logic [rocm_pkg::POS_W-1:0]   y_start,
    input  logic [rocm_pkg::LEN_W-1:0]   rect_width,
    input  logic [rocm_pkg::LEN_W-1:0]   rect_height,
    output logic                         q_valid,
    input  logic                         q_ready,
    output rocm_pkg::item_t              q_item
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    rocm_pkg::item_t            fifo_reg [Q_DEPTH];
    rocm_pkg::item_t            entry;
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [rocm_pkg::SUM_W-1:0] sum_x;
    logic [rocm_pkg::SUM_W-1:0] sum_y;
    logic                       clip_x;
    logic                       clip_y;
    logic                       push;
    logic                       pop;

    // Clip the rectangle to the grid and mark requests that touch no cell.
    always_comb
    begin
        sum_x  = rocm_pkg::SUM_W'(x_start) + rocm_pkg::SUM_W'(rect_width);
        sum_y  = rocm_pkg::SUM_W'(y_start) + rocm_pkg::SUM_W'(rect_height);
        clip_x = 32'(sum_x) > GRID_SIDE;
        clip_y = 32'(sum_y) > GRID_SIDE;

        entry.cmd     = rocm_pkg::cmd_t'(cmd);
        entry.id      = claim_id;
        entry.x0      = rocm_pkg::COORD_W'(x_start);
        entry.y0      = rocm_pkg::COORD_W'(y_start);
        entry.x_end   = clip_x ? rocm_pkg::COORD_W'(GRID_SIDE) : rocm_pkg::COORD_W'(sum_x);
        entry.y_end   = clip_y ? rocm_pkg::COORD_W'(GRID_SIDE) : rocm_pkg::COORD_W'(sum_y);
        entry.clipped = clip_x | clip_y;
        entry.empty   = (entry.x_end <= entry.x0) | (entry.y_end <= entry.y0);
    end

    assign in_ready = cnt_reg != CNT_W'(Q_DEPTH);
    assign q_valid  = cnt_reg != '0;
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid & in_ready;
    assign pop      = q_valid & q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/rocm_back.sv =====
module rocm_back #(
    parameter int GRID_SIDE = rocm_pkg::GRID_SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  rocm_pkg::item_t               q_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rocm_pkg::ID_W-1:0]     echo_id,
    output logic [rocm_pkg::COUNT_W-1:0]  overlap_cells,
    output logic                          overlap_found,
    output logic                          clipped
);

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t                          state_reg;
    rocm_pkg::item_t                 item_reg;
    logic [AW-1:0]                   clr_addr_reg;
    logic [rocm_pkg::COORD_W-1:0]    x_reg;
    logic [rocm_pkg::COORD_W-1:0]    y_reg;
    logic [AW-1:0]                   row_base_reg;
    logic                            p1_valid_reg;
    logic [AW-1:0]                   p1_addr_reg;
    logic                            found_reg;
    logic [rocm_pkg::COUNT_W-1:0]    count_reg;
    logic                            out_valid_reg;
    logic [rocm_pkg::ID_W-1:0]       echo_id_reg;
    logic [rocm_pkg::COUNT_W-1:0]    overlap_cells_reg;
    logic                            overlap_found_reg;
    logic                            clipped_reg;

    rocm_pkg::cell_t                 mem [DEPTH];
    rocm_pkg::cell_t                 rdata_reg;
    rocm_pkg::cell_t                 cell_new;
    rocm_pkg::cell_t                 wdata;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   waddr;
    logic                            rd_en;
    logic                            we;
    logic                            paint_upd;
    logic                            out_free;
    logic                            result_load;

    assign rd_addr   = row_base_reg + AW'(x_reg);
    assign rd_en     = state_reg == ST_RUN;
    assign paint_upd = p1_valid_reg && (item_reg.cmd == rocm_pkg::CMD_PAINT);
    assign we        = (state_reg == ST_CLEAR) || paint_upd;
    assign waddr     = (state_reg == ST_CLEAR) ? clr_addr_reg : p1_addr_reg;
    assign wdata     = (state_reg == ST_CLEAR) ? rocm_pkg::CELL_EMPTY : cell_new;
    assign out_free  = !out_valid_reg || out_ready;
    assign q_ready   = state_reg == ST_IDLE;
    // Wait for the last write so the count and flag are final.
    assign result_load = (state_reg == ST_DRAIN) && !p1_valid_reg && out_free;

    always_comb
    begin
        unique case (rdata_reg)
            rocm_pkg::CELL_EMPTY: cell_new = rocm_pkg::CELL_ONCE;
            rocm_pkg::CELL_ONCE:  cell_new = rocm_pkg::CELL_MULTI;
            default:              cell_new = rocm_pkg::CELL_MULTI;
        endcase
    end

    // Read in the issue cycle, write the stepped value in the cycle after.
    // Cells of one rectangle are distinct, so the two never collide.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            item_reg          <= '0;
            clr_addr_reg      <= '0;
            x_reg             <= '0;
            y_reg             <= '0;
            row_base_reg      <= '0;
            p1_valid_reg      <= 1'b0;
            p1_addr_reg       <= '0;
            found_reg         <= 1'b0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            echo_id_reg       <= '0;
            overlap_cells_reg <= '0;
            overlap_found_reg <= 1'b0;
            clipped_reg       <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= rd_en;
            p1_addr_reg  <= rd_addr;

            if (p1_valid_reg)
            begin
                if (item_reg.cmd == rocm_pkg::CMD_PAINT)
                begin
                    if (rdata_reg == rocm_pkg::CELL_ONCE &&
                        count_reg != {rocm_pkg::COUNT_W{1'b1}})
                    begin
                        count_reg <= count_reg + rocm_pkg::COUNT_W'(1);
                    end
                end
                else if (rdata_reg == rocm_pkg::CELL_MULTI)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg     <= q_item;
                        x_reg        <= q_item.x0;
                        y_reg        <= q_item.y0;
                        row_base_reg <= AW'(q_item.y0 * GRID_SIDE);
                        found_reg    <= 1'b0;
                        state_reg    <= q_item.empty ? ST_DRAIN : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (x_reg + rocm_pkg::COORD_W'(1) == item_reg.x_end)
                    begin
                        x_reg <= item_reg.x0;
                        if (y_reg + rocm_pkg::COORD_W'(1) == item_reg.y_end)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            y_reg        <= y_reg + rocm_pkg::COORD_W'(1);
                            row_base_reg <= row_base_reg + AW'(GRID_SIDE);
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + rocm_pkg::COORD_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (result_load)
                    begin
                        echo_id_reg       <= item_reg.id;
                        overlap_cells_reg <= count_reg;
                        overlap_found_reg <= (item_reg.cmd == rocm_pkg::CMD_CHECK) && found_reg;
                        clipped_reg       <= item_reg.clipped;
                        state_reg         <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign echo_id       = echo_id_reg;
    assign overlap_cells = overlap_cells_reg;
    assign overlap_found = overlap_found_reg;
    assign clipped       = clipped_reg;

endmodule

// ===== rtl/rectangle_overlap_coverage_map_unit.sv =====
// Rectangle coverage map: a GRID_SIDE x GRID_SIDE grid of 2-bit cells.
// Input channel (in_valid/in_ready) takes one request: cmd 0 paints the
// rectangle, cmd 1 checks it for multiply covered cells. Rectangles that
// reach past the grid are clipped and flagged.
// Output channel (out_valid/out_ready) returns one result per request with
// the claim id, the running count of multiply covered cells, the overlap
// flag of a check and the clip flag.
// The cell engine walks the clipped rectangle of a request one cell per
// cycle through a read-modify-write pipeline on the cell memory, which has
// one read port and one write port; an empty rectangle skips the walk.
// A two-entry queue sits in front of the engine, so requests are taken
// while the engine works or while a result waits in the output register.
// After reset the engine clears the grid, one cell per cycle; up to two
// requests are queued meanwhile. A stalled receiver holds the result; the
// engine still takes the next request, finishes it and waits with it until
// the output register frees, so the queue then fills and in_ready drops.
module rectangle_overlap_coverage_map_unit #(
    parameter int GRID_SIDE = rocm_pkg::GRID_SIDE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [rocm_pkg::ID_W-1:0]     claim_id,
    input  logic [rocm_pkg::POS_W-1:0]    x_start,
    input  logic [rocm_pkg::POS_W-1:0]    y_start,
    input  logic [rocm_pkg::LEN_W-1:0]    rect_width,
    input  logic [rocm_pkg::LEN_W-1:0]    rect_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rocm_pkg::ID_W-1:0]     echo_id,
    output logic [rocm_pkg::COUNT_W-1:0]  overlap_cells,
    output logic                          overlap_found,
    output logic                          clipped
);

    logic            q_valid;
    logic            q_ready;
    rocm_pkg::item_t q_item;

    rocm_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .claim_id    (claim_id),
        .x_start     (x_start),
        .y_start     (y_start),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    rocm_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_id       (echo_id),
        .overlap_cells (overlap_cells),
        .overlap_found (overlap_found),
        .clipped       (clipped)
    );

endmodule

// ===== rtl/rocm_checker.sv =====
module rocm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          cmd,
    input logic [rocm_pkg::ID_W-1:0]     claim_id,
    input logic [rocm_pkg::POS_W-1:0]    x_start,
    input logic [rocm_pkg::POS_W-1:0]    y_start,
    input logic [rocm_pkg::LEN_W-1:0]    rect_width,
    input logic [rocm_pkg::LEN_W-1:0]    rect_height,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rocm_pkg::ID_W-1:0]     echo_id,
    input logic [rocm_pkg::COUNT_W-1:0]  overlap_cells,
    input logic                          overlap_found,
    input logic                          clipped
);

    // Queue entries, the item in the engine and the output register.
    localparam int MAX_PENDING = 4;
    localparam int PEND_W      = $clog2(MAX_PENDING + 1);

    logic [PEND_W-1:0]             pending_reg;
    logic [rocm_pkg::COUNT_W-1:0]  last_count_reg;
    logic                          in_acc;
    logic                          out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_count_reg <= '0;
        end
        else
        begin
            if (in_acc && !out_acc)
            begin
                pending_reg <= pending_reg + PEND_W'(1);
            end
            else if (out_acc && !in_acc)
            begin
                pending_reg <= pending_reg - PEND_W'(1);
            end
            if (out_acc)
            begin
                last_count_reg <= overlap_cells;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echo_id) &&
            $stable(overlap_cells) && $stable(overlap_found) && $stable(clipped))
        else $error("result changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result without an outstanding request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(MAX_PENDING))
        else $error("more requests in flight than the design can hold");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> overlap_cells >= last_count_reg)
        else $error("overlap count went down");

    a_found_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overlap_found |-> overlap_cells != '0)
        else $error("overlap reported with no multiply covered cell");

endmodule

bind rectangle_overlap_coverage_map_unit rocm_checker u_rocm_checker (.*);

// ===== tb/rectangle_overlap_coverage_map_unit_test.sv =====
`timescale 1ns / 1ps

module rectangle_overlap_coverage_map_unit_test;

    localparam int GRID        = rocm_pkg::GRID_SIDE_DEF;
    localparam int POS_MAX     = (1 << rocm_pkg::POS_W) - 1;
    localparam int ID_MAX      = (1 << rocm_pkg::ID_W) - 1;
    localparam int LEN_MAX     = GRID;
    localparam int COUNT_MAX   = (1 << rocm_pkg::COUNT_W) - 1;
    localparam int ITEM_TOTAL  = 580;
    localparam int TAIL_CYCLES = 16;
    // The limit covers the grid clear after reset, then about 600 requests of up
    // to about 2k cells each, with random stalls on both sides, and leaves a
    // wide margin.
    localparam int CYCLE_LIMIT = 8_000_000;

    typedef struct {
        rocm_pkg::cmd_t                cmd;
        logic [rocm_pkg::ID_W-1:0]     id;
        logic [rocm_pkg::POS_W-1:0]    x;
        logic [rocm_pkg::POS_W-1:0]    y;
        logic [rocm_pkg::LEN_W-1:0]    w;
        logic [rocm_pkg::LEN_W-1:0]    h;
    } claim_req_t;

    typedef struct {
        logic [rocm_pkg::ID_W-1:0]     id;
        logic [rocm_pkg::COUNT_W-1:0]  count;
        logic                          found;
        logic                          clip;
    } claim_result_t;

    typedef struct {
        claim_req_t         req;
        bit                 typed;
        claim_result_t      want;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          cmd;
    logic [rocm_pkg::ID_W-1:0]     claim_id;
    logic [rocm_pkg::POS_W-1:0]    x_start;
    logic [rocm_pkg::POS_W-1:0]    y_start;
    logic [rocm_pkg::LEN_W-1:0]    rect_width;
    logic [rocm_pkg::LEN_W-1:0]    rect_height;
    logic                          out_valid;
    logic                          out_ready;
    logic [rocm_pkg::ID_W-1:0]     echo_id;
    logic [rocm_pkg::COUNT_W-1:0]  overlap_cells;
    logic                          overlap_found;
    logic                          clipped;

    // Predictor state: cells that were never painted are absent from the map.
    rocm_pkg::cell_t     cover_map [int];
    int                  multi_total;

    claim_result_t       pending_results [$];
    plan_row_t           directed_plan [$];
    claim_result_t       oldest;
    int                  mismatches;
    int                  items_sent;
    int                  cycle_count;
    int                  stall_left;
    bit                  steady_flow;

    rectangle_overlap_coverage_map_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .claim_id      (claim_id),
        .x_start       (x_start),
        .y_start       (y_start),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .echo_id       (echo_id),
        .overlap_cells (overlap_cells),
        .overlap_found (overlap_found),
        .clipped       (clipped)
    );

    always #5 clk = ~clk;

    function automatic claim_result_t predict_claim(input claim_req_t r);
        claim_result_t   res;
        int              x_end;
        int              y_end;
        int              x;
        int              y;
        int              at;
        rocm_pkg::cell_t c;
        bit              cut;
        bit              hit;
        cut = 1'b0;
        hit = 1'b0;
        x_end = int'(r.x) + int'(r.w);
        y_end = int'(r.y) + int'(r.h);
        if (x_end > GRID)
        begin
            cut = 1'b1;
            x_end = GRID;
        end
        if (y_end > GRID)
        begin
            cut = 1'b1;
            y_end = GRID;
        end
        for (y = int'(r.y); y < y_end; y++)
        begin
            for (x = int'(r.x); x < x_end; x++)
            begin
                at = y * GRID + x;
                c = cover_map.exists(at) ? cover_map[at] : rocm_pkg::CELL_EMPTY;
                if (r.cmd == rocm_pkg::CMD_PAINT)
                begin
                    if (c == rocm_pkg::CELL_EMPTY)
                        cover_map[at] = rocm_pkg::CELL_ONCE;
                    else if (c == rocm_pkg::CELL_ONCE)
                    begin
                        cover_map[at] = rocm_pkg::CELL_MULTI;
                        if (multi_total < COUNT_MAX)
                            multi_total++;
                    end
                end
                else if (c == rocm_pkg::CELL_MULTI)
                    hit = 1'b1;
            end
        end
        res.id    = r.id;
        res.count = multi_total[rocm_pkg::COUNT_W-1:0];
        res.found = (r.cmd == rocm_pkg::CMD_CHECK) && hit;
        res.clip  = cut;
        return res;
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic claim_req_t random_claim(input rocm_pkg::cmd_t op, input int base_x,
                                                input int base_y);
        claim_req_t r;
        int         px;
        int         py;
        int         shape;
        px = base_x + $urandom_range(0, 15);
        py = base_y + $urandom_range(0, 15);
        if (px > POS_MAX)
            px = POS_MAX;
        if (py > POS_MAX)
            py = POS_MAX;
        r.cmd = op;
        r.id  = rocm_pkg::ID_W'($urandom_range(0, ID_MAX));
        r.x   = px[rocm_pkg::POS_W-1:0];
        r.y   = py[rocm_pkg::POS_W-1:0];
        shape = $urandom_range(0, 99);
        if (shape < 4)
        begin
            r.w = '0;
            r.h = rocm_pkg::LEN_W'($urandom_range(0, 20));
        end
        else if (shape < 8)
        begin
            r.w = rocm_pkg::LEN_W'($urandom_range(0, 20));
            r.h = '0;
        end
        else if (shape < 14)
        begin
            r.w = rocm_pkg::LEN_W'($urandom_range(0, LEN_MAX));
            r.h = rocm_pkg::LEN_W'($urandom_range(0, 2));
        end
        else if (shape < 20)
        begin
            r.w = rocm_pkg::LEN_W'($urandom_range(0, 2));
            r.h = rocm_pkg::LEN_W'($urandom_range(0, LEN_MAX));
        end
        else
        begin
            r.w = rocm_pkg::LEN_W'($urandom_range(1, 20));
            r.h = rocm_pkg::LEN_W'($urandom_range(1, 20));
        end
        return r;
    endfunction

    function automatic void add_row(input rocm_pkg::cmd_t op, input int id, input int x,
                                    input int y, input int w, input int h,
                                    input bit typed = 1'b0, input int count = 0,
                                    input bit found = 1'b0, input bit clip = 1'b0);
        plan_row_t row;
        row.req.cmd   = op;
        row.req.id    = rocm_pkg::ID_W'(id);
        row.req.x     = rocm_pkg::POS_W'(x);
        row.req.y     = rocm_pkg::POS_W'(y);
        row.req.w     = rocm_pkg::LEN_W'(w);
        row.req.h     = rocm_pkg::LEN_W'(h);
        row.typed     = typed;
        row.want.id   = rocm_pkg::ID_W'(id);
        row.want.count = rocm_pkg::COUNT_W'(count);
        row.want.found = found;
        row.want.clip  = clip;
        directed_plan.push_back(row);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with in_valid still high, so a following request can go back to back.
    task automatic send_request(input claim_req_t r, input bit typed = 1'b0,
                                input claim_result_t want = '{default: '0});
        int            gap;
        claim_result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= r.cmd;
        claim_id    <= r.id;
        x_start     <= r.x;
        y_start     <= r.y;
        rect_width  <= r.w;
        rect_height <= r.h;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_claim(r);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    initial
    begin : stimulus
        claim_req_t round_claims [8];
        claim_req_t one;
        int         k;
        int         i;
        int         zone;
        int         bx;
        int         by;
        bit         drained;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cmd         = rocm_pkg::CMD_PAINT;
        claim_id    = '0;
        x_start     = '0;
        y_start     = '0;
        rect_width  = '0;
        rect_height = '0;
        mismatches  = 0;
        items_sent  = 0;
        multi_total = 0;
        steady_flow = 1'b0;
        drained     = 1'b0;

        // Empty grid after reset, then the bottom-right corner with both lengths
        // at LEN_MAX (the grid side), then a zero-width paint.
        add_row(rocm_pkg::CMD_CHECK, 0, 0, 0, 4, 4, 1'b1, 0, 1'b0, 1'b0);
        add_row(rocm_pkg::CMD_PAINT, ID_MAX, POS_MAX, POS_MAX, LEN_MAX, LEN_MAX,
                1'b1, 0, 1'b0, 1'b1);
        add_row(rocm_pkg::CMD_PAINT, 1, 0, 0, 0, 7, 1'b1, 0, 1'b0, 1'b0);
        add_row(rocm_pkg::CMD_CHECK, 2, POS_MAX, POS_MAX, 1, 1, 1'b1, 0, 1'b0, 1'b0);
        add_row(rocm_pkg::CMD_PAINT, 3, POS_MAX, POS_MAX, 1, 1, 1'b1, 1, 1'b0, 1'b0);
        add_row(rocm_pkg::CMD_CHECK, 4, 1022, 1022, 2, 2);
        add_row(rocm_pkg::CMD_PAINT, 5, 0, 0, 4, 4);
        add_row(rocm_pkg::CMD_PAINT, 6, 2, 2, 4, 4);
        add_row(rocm_pkg::CMD_CHECK, 7, 0, 0, 2, 2);
        add_row(rocm_pkg::CMD_CHECK, 8, 3, 3, 1, 1);
        add_row(rocm_pkg::CMD_CHECK, 9, 3, 3, 0, 0);
        add_row(rocm_pkg::CMD_CHECK, 10, 2, 2, 5, 0);
        add_row(rocm_pkg::CMD_PAINT, 11, 0, 10, LEN_MAX, 1);
        add_row(rocm_pkg::CMD_PAINT, 12, 1000, 10, 100, 1);
        add_row(rocm_pkg::CMD_PAINT, 13, 10, 0, 1, LEN_MAX);
        add_row(rocm_pkg::CMD_CHECK, 14, 0, 10, LEN_MAX, 1);
        add_row(rocm_pkg::CMD_CHECK, 15, POS_MAX, 0, LEN_MAX, LEN_MAX);
        add_row(rocm_pkg::CMD_PAINT, 16, 512, 700, LEN_MAX, 2);
        add_row(rocm_pkg::CMD_PAINT, 17, 300, 1020, 3, 8);
        add_row(rocm_pkg::CMD_CHECK, 18, 300, 1016, 3, LEN_MAX);
        add_row(rocm_pkg::CMD_PAINT, 19, 341, 682, 1023, 1);
        add_row(rocm_pkg::CMD_CHECK, 20, 682, 341, 1, 1023);
        // A claim alone in its area must report no overlap.
        add_row(rocm_pkg::CMD_PAINT, 4094, 600, 600, 16, 16);
        add_row(rocm_pkg::CMD_CHECK, 4094, 600, 600, 16, 16);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_plan[n])
            send_request(directed_plan[n].req, directed_plan[n].typed, directed_plan[n].want);

        // Rounds of claims painted and then checked, mixed with runs of one to
        // three noise requests.
        while (items_sent < ITEM_TOTAL)
        begin
            if (!drained && items_sent >= ITEM_TOTAL / 2)
            begin
                wait_for_results();
                drained = 1'b1;
            end
            steady_flow = ($urandom_range(0, 5) == 0);
            zone = $urandom_range(0, 99);
            if (zone < 60)
            begin
                bx = $urandom_range(0, 200);
                by = $urandom_range(0, 200);
            end
            else if (zone < 85)
            begin
                bx = $urandom_range(0, POS_MAX);
                by = $urandom_range(0, POS_MAX);
            end
            else if (zone < 93)
            begin
                bx = $urandom_range(1000, POS_MAX);
                by = $urandom_range(0, POS_MAX);
            end
            else
            begin
                bx = $urandom_range(0, POS_MAX);
                by = $urandom_range(1000, POS_MAX);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                k = $urandom_range(2, 8);
                for (i = 0; i < k; i++)
                begin
                    round_claims[i] = random_claim(rocm_pkg::CMD_PAINT, bx, by);
                    send_request(round_claims[i]);
                end
                for (i = 0; i < k; i++)
                begin
                    one = round_claims[i];
                    one.cmd = rocm_pkg::CMD_CHECK;
                    send_request(one);
                end
            end
            else
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                begin
                    one = random_claim(rocm_pkg::cmd_t'($urandom_range(0, 1)), bx, by);
                    send_request(one);
                end
            end
        end

        steady_flow = 1'b0;
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("rectangle_overlap_coverage_map_unit: match");
        else
            $display("rectangle_overlap_coverage_map_unit: mismatch");
        $finish;
    end

    initial
    begin : receiver
        out_ready  = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request waiting: echo_id=%0d overlap_cells=%0d",
                             echo_id, overlap_cells);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (echo_id !== oldest.id || overlap_cells !== oldest.count ||
                    overlap_found !== oldest.found || clipped !== oldest.clip)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected id=%0d count=%0d found=%0d clip=%0d, got id=%0d count=%0d found=%0d clip=%0d",
                                 oldest.id, oldest.count, oldest.found, oldest.clip,
                                 echo_id, overlap_cells, overlap_found, clipped);
                end
            end
        end
    end

    initial
    begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("rectangle_overlap_coverage_map_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rocm_pkg.sv
rtl/rocm_front.sv
rtl/rocm_back.sv
rtl/rectangle_overlap_coverage_map_unit.sv
rtl/rocm_checker.sv
tb/rectangle_overlap_coverage_map_unit_test.sv
